// File: rtl/core/swrd_pkg.sv
// Shared types, constants and the elaboration-time log helper of the RMS level meter.
package swrd_pkg;

   // Sample and level field widths
   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 16;

   // Fraction bits of the base-2 logarithm
   localparam int FRAC_BITS = 16;
   localparam int CNT_W     = $clog2(FRAC_BITS);

   // log2 of full-scale energy (2^30 per sample)
   localparam int FULL_SCALE_LOG2 = 30;

   // 256 * 10 * log10(2) in Q.16
   localparam int K_W = 26;
   localparam logic [K_W-1:0] DB_PER_LOG2_Q16 = 26'd50504453;

   // Level floor of -100 dB in 1/256 dB
   localparam int FLOOR_MAG = 25600;
   localparam logic signed [LEVEL_W-1:0] FLOOR_DB_Q8 = -16'sd25600;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_NORM,
      ST_LOG,
      ST_SCALE,
      ST_ROUND,
      ST_OUT
   } swrd_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic take;
      logic square;
      logic accum;
      logic norm_step;
      logic mant_load;
      logic log_step;
      logic scale;
      logic round;
      logic zero_level;
      logic publish;
   } swrd_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic sum_zero;
      logic norm_done;
      logic log_last;
      logic out_free;
   } swrd_stat_type;

   // Q.16 base-2 logarithm of a constant, truncated exactly as the datapath does it
   function automatic logic [31:0] log2_q16_const(input longint unsigned v);
      longint unsigned m;
      int unsigned     n;
      logic [31:0]     frac;
      n    = 0;
      frac = '0;
      for (int b = 0; b < 63; b++) begin
         if ((v >> (b + 1)) != 0) begin
            n = b + 1;
         end
      end
      if (n > 31) begin
         m = v >> (n - 31);
      end else begin
         m = v << (31 - n);
      end
      for (int i = 0; i < FRAC_BITS; i++) begin
         m    = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            frac = frac | 32'd1;
            m    = m >> 1;
         end
      end
      return ({16'(n), 16'd0}) | frac;
   endfunction

endpackage

// File: rtl/core/swrd_sample_if.sv
// Sample stream interface: one signed audio sample per transfer.
interface swrd_sample_if;
   import swrd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] audio_sample;

   modport source (output valid, output audio_sample, input ready);
   modport sink   (input valid, input audio_sample, output ready);
endinterface

// File: rtl/core/swrd_level_if.sv
// Level stream interface: one dB level per transfer.
interface swrd_level_if;
   import swrd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [LEVEL_W-1:0] level_db;

   modport source (output valid, output level_db, input ready);
   modport sink   (input valid, input level_db, output ready);
endinterface

// File: rtl/core/swrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swrd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/swrd_ctrl.sv
// Sequencing controller of the RMS level meter.
module swrd_ctrl import swrd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  swrd_stat_type stat,
   output swrd_cmd_type  cmd
);

   swrd_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_NORM;
         ST_NORM: begin
            if (stat.sum_zero) begin
               state_in = ST_OUT;
            end else if (stat.norm_done) begin
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            if (stat.log_last) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_ROUND;
         ST_ROUND: state_in = ST_OUT;
         ST_OUT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_SQUARE: cmd.square = 1'b1;
         ST_ACCUM:  cmd.accum  = 1'b1;
         ST_NORM: begin
            if (stat.sum_zero) begin
               cmd.zero_level = 1'b1;
            end else if (stat.norm_done) begin
               cmd.mant_load = 1'b1;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_LOG:   cmd.log_step = 1'b1;
         ST_SCALE: cmd.scale    = 1'b1;
         ST_ROUND: cmd.round    = 1'b1;
         ST_OUT:   cmd.publish  = stat.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   // At most one datapath command is issued per cycle.
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command at once");

   // A transfer in is followed by the squaring step.
   assert property (@(posedge clock) disable iff (reset) cmd.take |=> cmd.square)
      else $error("accepted sample not squared in the next cycle");

   // The logarithm leaves only through scaling.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.log_step && stat.log_last) |=> cmd.scale)
      else $error("last log step not followed by scaling");

endmodule

// File: rtl/core/swrd_datapath.sv
// Datapath of the RMS level meter: sample ring, energy sum, iterative log2, dB scaling.
module swrd_datapath import swrd_pkg::*; #(
   parameter int WINDOW = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  swrd_cmd_type               cmd,
   output swrd_stat_type              stat,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [LEVEL_W-1:0]  rsp_level
);

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int SQ_W   = 31;
   localparam int SUM_W  = 31 + $clog2(WINDOW);
   localparam int EXP_W  = $clog2(SUM_W);
   localparam int LOG_W  = EXP_W + FRAC_BITS;
   localparam int D_W    = LOG_W + 2;
   localparam int P_W    = D_W + K_W;
   localparam int Q_W    = P_W + 1 - 32;
   localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW) << FULL_SCALE_LOG2;
   localparam logic signed [D_W-1:0] LOG2_WIN_Q = D_W'(log2_q16_const(64'(WINDOW)));
   localparam logic signed [D_W-1:0] FULL_Q = D_W'(FULL_SCALE_LOG2) << FRAC_BITS;

   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic                       wrapped_ff, wrapped_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0]        ring_rdata;
   logic [SQ_W-1:0]            old_sq_ff, new_sq_ff;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [SUM_W-1:0]           norm_ff, norm_in;
   logic [EXP_W-1:0]           exp_ff, exp_in;
   logic [31:0]                m_ff, m_in;
   logic [FRAC_BITS-1:0]       frac_ff, frac_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [P_W-1:0]             prod_ff;
   logic                       nonneg_ff;
   logic signed [LEVEL_W-1:0]  level_ff, level_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0]  rsp_level_ff;

   logic signed [SAMPLE_W-1:0]   old_s;
   logic signed [2*SAMPLE_W-1:0] old_prod, new_prod;
   logic [63:0]                  m_sq;
   logic [LOG_W-1:0]             log2_sum;
   logic signed [D_W-1:0]        d_val;
   logic [D_W-1:0]               mag;
   logic [P_W:0]                 rounded;
   logic [Q_W-1:0]               q_val;

   // Ring of the most recent samples; the slot about to be replaced is read ahead
   swrd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock (clock),
      .we    (cmd.accum),
      .waddr (slot_ff),
      .wdata (sample_ff),
      .raddr (slot_ff),
      .rdata (ring_rdata)
   );

   // Slots never written since reset read as silence until the ring has wrapped once.
   assign old_s    = wrapped_ff ? $signed(ring_rdata) : '0;
   assign old_prod = old_s * old_s;
   assign new_prod = sample_ff * sample_ff;

   // Write pointer and wrap flag
   always_comb begin
      slot_in    = slot_ff;
      wrapped_in = wrapped_ff;
      if (cmd.accum) begin
         if (slot_ff == SLOT_W'(WINDOW - 1)) begin
            slot_in    = '0;
            wrapped_in = 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   // Running energy: add the new square, drop the one leaving the window.
   assign sum_in = cmd.accum ? (sum_ff - SUM_W'(old_sq_ff) + SUM_W'(new_sq_ff)) : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= '0;
      end else begin
         slot_ff    <= slot_in;
         wrapped_ff <= wrapped_in;
         sum_ff     <= sum_in;
      end
   end

   // Sample latch and squares
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sample_ff <= req_sample;
      end
      if (cmd.square) begin
         old_sq_ff <= SQ_W'(old_prod);
         new_sq_ff <= SQ_W'(new_prod);
      end
   end

   // Normalisation: eight bits a step while the top byte is clear, else one.
   always_comb begin
      norm_in = norm_ff;
      exp_in  = exp_ff;
      if (cmd.accum) begin
         norm_in = sum_in;
         exp_in  = EXP_W'(SUM_W - 1);
      end else if (cmd.norm_step) begin
         if (norm_ff[SUM_W-1 -: 8] == 8'd0) begin
            norm_in = norm_ff << 8;
            exp_in  = exp_ff - EXP_W'(8);
         end else begin
            norm_in = norm_ff << 1;
            exp_in  = exp_ff - 1'b1;
         end
      end
   end

   // Mantissa squaring: one fraction bit per step.
   assign m_sq = 64'(m_ff) * 64'(m_ff);

   always_comb begin
      m_in    = m_ff;
      frac_in = frac_ff;
      cnt_in  = cnt_ff;
      if (cmd.mant_load) begin
         m_in    = norm_ff[SUM_W-1 -: 32];
         frac_in = '0;
         cnt_in  = '0;
      end else if (cmd.log_step) begin
         cnt_in = cnt_ff + 1'b1;
         if (m_sq[63]) begin
            m_in    = m_sq[63:32];
            frac_in = {frac_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            m_in    = m_sq[62:31];
            frac_in = {frac_ff[FRAC_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      norm_ff <= norm_in;
      exp_ff  <= exp_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
   end

   // Level relative to full scale in Q.16 log2 units, then scaled to 1/256 dB.
   assign log2_sum = {exp_ff, frac_ff};
   assign d_val    = $signed(D_W'(log2_sum)) - LOG2_WIN_Q - FULL_Q;
   assign mag      = D_W'(-d_val);

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         nonneg_ff <= ~d_val[D_W-1];
         prod_ff   <= P_W'(mag) * P_W'(DB_PER_LOG2_Q16);
      end
   end

   // Rounding half up and clamping to the floor and to 0 dB
   assign rounded = (P_W+1)'(prod_ff) + ((P_W+1)'(1) << 31);
   assign q_val   = rounded[P_W:32];

   always_comb begin
      level_in = level_ff;
      if (cmd.zero_level) begin
         level_in = FLOOR_DB_Q8;
      end else if (cmd.round) begin
         if (nonneg_ff) begin
            level_in = '0;
         end else if (q_val >= Q_W'(FLOOR_MAG)) begin
            level_in = FLOOR_DB_Q8;
         end else begin
            level_in = -$signed(LEVEL_W'(q_val));
         end
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   // Output register: holds the level until the transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.publish) begin
         rsp_level_ff <= level_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

   // Status to the controller
   assign stat.sum_zero  = (sum_ff == '0);
   assign stat.norm_done = norm_ff[SUM_W-1];
   assign stat.log_last  = (cnt_ff == CNT_W'(FRAC_BITS - 1));
   assign stat.out_free  = ~rsp_valid_ff | rsp_ready;

   // The energy never exceeds a window of full-scale samples.
   assert property (@(posedge clock) disable iff (reset) sum_ff <= SUM_MAX)
      else $error("energy sum out of range");

   // The mantissa stays normalised through the squaring steps.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.mant_load || cmd.log_step) |=> m_ff[31])
      else $error("mantissa lost its leading one");

   // A waiting level is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.publish)
      else $error("level published over an untaken result");

   // Levels lie between the floor and full scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff <= 0 && rsp_level_ff >= FLOOR_DB_Q8))
      else $error("level out of range");

endmodule

// File: rtl/core/sliding_window_rms_db.sv
// Top level of the sliding-window RMS level meter in decibels.
//
// req_if carries one signed Q1.15 audio sample per transfer; rsp_if returns,
// for every sample, 10*log10 of the mean square of the last WINDOW samples
// relative to full scale, in 1/256 dB, clamped to -100 dB .. 0 dB. A window
// with no energy reads -100 dB.
// One sample is processed at a time. From the transfer in to the level being
// offered, the steps are: square, accumulate, a leading-one search (eight bits
// or one bit per step over the energy word, then the mantissa load), the
// 32x32 squaring unit stepped once per fraction bit of the log2, then scaling,
// rounding and the output register. A window with no energy skips the
// leading-one search and the logarithm and loads the floor level. A new
// sample is taken only after the level of the previous one has been loaded.
// The level sits in an output register: if the receiver stalls, processing of
// the next sample runs on and waits only to load its own level.
// Reset (synchronous) empties the window: the sample ring reads as silence
// until it has been filled once, the energy sum and pointer clear, and any
// pending level is dropped. No clearing pass is needed.
module sliding_window_rms_db import swrd_pkg::*; #(
   parameter int WINDOW = 256
) (
   input  logic         clock,
   input  logic         reset,
   swrd_sample_if.sink  req_if,
   swrd_level_if.source rsp_if
);

   swrd_cmd_type  cmd;
   swrd_stat_type stat;

   // Sequencer
   swrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Ring, energy and level arithmetic
   swrd_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_sample (req_if.audio_sample),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_level  (rsp_if.level_db)
   );

endmodule

// File: dv/sliding_window_rms_db_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the sliding-window RMS level meter in decibels.
module sliding_window_rms_db_tb;
   import swrd_pkg::*;

   localparam int WINDOW       = 256;
   localparam int RANDOM_ITEMS = 1100;
   localparam int LIMIT        = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int IDLE_PCT     = 15;
   localparam int CALM_START   = 12000;
   localparam int CALM_END     = 20000;
   localparam int HOLD_START   = 6000;
   localparam int HOLD_CYCLES  = 400;

   // Own copies of the level scaling constants.
   localparam int                         LOG_FRAC   = 16;
   localparam int                         FS_LOG2    = 30;
   localparam longint unsigned            DB_PER_OCT = 64'd50504453;
   localparam int                         FLOOR_Q8   = 25600;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   logic clock;
   logic reset;

   swrd_sample_if req_if ();
   swrd_level_if  rsp_if ();

   sliding_window_rms_db #(.WINDOW(WINDOW)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic signed [SAMPLE_W-1:0] pending_samples[$];
   logic signed [LEVEL_W-1:0]  expected_levels[$];

   // Predictor state: the sample window, its oldest slot and its energy.
   logic signed [SAMPLE_W-1:0] window_ring[WINDOW];
   int unsigned                oldest_slot;
   longint unsigned            window_energy;

   int  cycle_count     = 0;
   int  mismatch_count  = 0;
   int  samples_taken   = 0;
   int  hold_left       = 0;
   bit  hold_done       = 1'b0;
   wire calm            = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

   // Base-2 logarithm in Q.16 with every fraction bit truncated.
   function automatic int unsigned log2_fixed(input longint unsigned v);
      int unsigned     msb;
      longint unsigned mant;
      int unsigned     frac;
      msb  = 0;
      frac = 0;
      for (int b = 0; b < 64; b++) begin
         if (v[b]) begin
            msb = b;
         end
      end
      if (msb > 31) begin
         mant = v >> (msb - 31);
      end else begin
         mant = v << (31 - msb);
      end
      repeat (LOG_FRAC) begin
         mant = (mant * mant) >> 31;
         frac = frac << 1;
         if (mant >= 64'h1_0000_0000) begin
            frac = frac | 1;
            mant = mant >> 1;
         end
      end
      return (msb << LOG_FRAC) | frac;
   endfunction

   // Level in 1/256 dB of a window energy, clamped to the floor and to full scale.
   function automatic logic signed [LEVEL_W-1:0] level_of_energy(input longint unsigned energy);
      longint          delta;
      longint unsigned mag;
      longint unsigned q;
      if (energy == 0) begin
         return LEVEL_W'(-FLOOR_Q8);
      end
      delta = longint'(log2_fixed(energy)) - longint'(log2_fixed(WINDOW))
              - (longint'(FS_LOG2) << LOG_FRAC);
      if (delta >= 0) begin
         return '0;
      end
      mag = -delta;
      q   = (mag * DB_PER_OCT + (64'd1 << 31)) >> 32;
      if (q >= FLOOR_Q8) begin
         return LEVEL_W'(-FLOOR_Q8);
      end
      return LEVEL_W'(-longint'(q));
   endfunction

   // Replaces the oldest sample, updates the energy and returns the new level.
   function automatic logic signed [LEVEL_W-1:0] advance_window(
      input logic signed [SAMPLE_W-1:0] x
   );
      logic signed [SAMPLE_W-1:0] leaving;
      leaving       = window_ring[oldest_slot];
      window_energy = window_energy - longint'(leaving) * longint'(leaving);
      window_energy = window_energy + longint'(x) * longint'(x);
      window_ring[oldest_slot] = x;
      oldest_slot   = (oldest_slot + 1) % WINDOW;
      return level_of_energy(window_energy);
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle counter for the idle schedule and the run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Sample driver: offers the next queued sample once the previous one has transferred.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_samples.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_if.valid        <= 1'b1;
            req_if.audio_sample <= pending_samples.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Level receiver: random stalls, one long hold-off, and a calm stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_done && cycle_count >= HOLD_START) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         hold_done    <= 1'b1;
      end else begin
         rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Monitor: predicts on each sample transfer and checks each level transfer.
   always @(posedge clock) begin : level_monitor
      logic signed [LEVEL_W-1:0] wanted;
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            window_ring[i] = '0;
         end
         oldest_slot   = 0;
         window_energy = 0;
         expected_levels.delete();
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_levels.push_back(advance_window(req_if.audio_sample));
            samples_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: unexpected level, expected none, actual %0d",
                        $time, rsp_if.level_db);
               mismatch_count++;
            end else begin
               wanted = expected_levels.pop_front();
               if (wanted !== rsp_if.level_db) begin
                  $display("%0t: level mismatch, expected %0d, actual %0d",
                           $time, wanted, rsp_if.level_db);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus
      logic signed [SAMPLE_W-1:0] s;
      int                         random_count;
      int                         burst_len;
      int                         shift;
      int                         total_items;

      reset = 1'b1;

      // Directed part: empty window first, then extremes and small values below the floor.
      pending_samples.push_back(16'sd0);
      pending_samples.push_back(16'sd0);
      pending_samples.push_back(16'sd1);
      pending_samples.push_back(-16'sd1);
      pending_samples.push_back(SAMPLE_MAX);
      pending_samples.push_back(SAMPLE_MIN);
      pending_samples.push_back(16'sh5555);
      pending_samples.push_back(16'shAAAA);
      pending_samples.push_back(16'sd256);
      pending_samples.push_back(-16'sd256);
      pending_samples.push_back(SAMPLE_MIN);
      pending_samples.push_back(SAMPLE_MIN);
      pending_samples.push_back(SAMPLE_MAX);
      pending_samples.push_back(16'sd0);
      pending_samples.push_back(16'sd2);
      pending_samples.push_back(16'sd181);
      pending_samples.push_back(-16'sd4096);
      pending_samples.push_back(16'sh4000);
      pending_samples.push_back(16'sd0);
      pending_samples.push_back(-16'sd32767);

      // A full window of negative full scale reaches 0 dB exactly.
      random_count = 0;
      repeat (WINDOW + 8) begin
         pending_samples.push_back(SAMPLE_MIN);
         random_count++;
      end
      // A full window of silence brings the energy back to zero.
      repeat (WINDOW + 2) begin
         pending_samples.push_back(16'sd0);
         random_count++;
      end
      // Bursts at random amplitude, with occasional extremes and full-range words.
      while (random_count < RANDOM_ITEMS) begin
         burst_len = $urandom_range(4, 40);
         shift     = $urandom_range(0, 15);
         for (int i = 0; i < burst_len; i++) begin
            case ($urandom_range(0, 9))
               0: begin
                  s = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
               end
               1: begin
                  s = 16'($urandom);
               end
               default: begin
                  s = $signed(16'($urandom)) >>> shift;
               end
            endcase
            pending_samples.push_back(s);
            random_count++;
         end
      end
      total_items = pending_samples.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait for every sample to transfer and every level to come back.
      while (!(samples_taken == total_items && expected_levels.size() == 0)
             && cycle_count < LIMIT) begin
         @(negedge clock);
      end
      if (cycle_count >= LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d levels outstanding",
                  $time, cycle_count, expected_levels.size());
         $display("Verification failed");
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         if (expected_levels.size() != 0) begin
            $display("%0t: %0d levels never arrived", $time, expected_levels.size());
         end
         if (mismatch_count == 0 && expected_levels.size() == 0) begin
            $display("Verification passed");
         end else begin
            $display("Verification failed");
         end
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/swrd_pkg.sv
rtl/core/swrd_sample_if.sv
rtl/core/swrd_level_if.sv
rtl/core/swrd_ram.sv
rtl/core/swrd_ctrl.sv
rtl/core/swrd_datapath.sv
rtl/core/sliding_window_rms_db.sv
dv/sliding_window_rms_db_tb.sv
